// ----- hdl/mss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, codes and constants of the multitone sine synthesizer,
// plus the quarter-wave sine entry function evaluated at elaboration.
// ----------------------------------------------------------------------------
package mss_pkg;

  // Default values of the top-level parameters
  localparam int MAX_HARMONICS_DEF   = 8;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int AMPLITUDE_BITS_DEF  = 16;

  // Fixed field widths
  localparam int OP_W       = 2;
  localparam int AMP_W      = 16;
  localparam int PHASE_W    = 32;
  localparam int SAMPLE_W   = 20;
  localparam int COUNT_W    = 4;
  localparam int INDEX_W    = 20;
  localparam int DC_W       = 16;
  localparam int RLEN_W     = 21;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 21;

  localparam int SAMPLE_MAX = 524287;
  localparam int SAMPLE_MIN = -524288;

  localparam logic [RLEN_W-1:0]  RLEN_RESET = RLEN_W'(1024);
  localparam logic [RLEN_W-1:0]  RLEN_MAX   = RLEN_W'(1048576);
  localparam logic [PHASE_W-1:0] NYQUIST    = 32'h8000_0000;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DC_OFFSET     = 4'd0,
    REG_RECORD_LENGTH = 4'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;       // item accepted, clear result flags
    logic add;
    logic clear;
    logic tick_begin;  // clear accumulator and visit counter
    logic visit;       // read the next harmonic into the pipeline
    logic round;       // round the sum, update sample index
    logic emit;        // load the output register
    logic emit_tick;   // result carries a sample
  } mss_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic visit_more;
    logic pipe_empty;
    logic out_free;
  } mss_stat_t;

  // unsigned restoring long division, only used for the table constants
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    int              b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // One quarter-wave entry: Taylor series in Q30, rounded half up to frac
  // bits and saturated just below one.
  function automatic longint unsigned sine_entry(input int unsigned i,
                                                 input int unsigned qbits,
                                                 input int unsigned frac);
    longint unsigned x;
    longint unsigned term;
    longint unsigned s;
    longint unsigned v;
    longint unsigned lim;
    int unsigned     shift;
    int unsigned     k;
    x = (longint'(i) * HALF_PI_Q30 + (64'd1 << (qbits - 1))) >> qbits;
    term  = x;
    s     = x;
    shift = 30 - frac;
    lim   = (64'd1 << frac) - 64'd1;
    for (k = 1; k <= 9; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = div_u64(term, 64'((2 * k) * (2 * k + 1)));
      if (k[0]) begin
        s = s - term;
      end else begin
        s = s + term;
      end
    end
    v = (s + (64'd1 << (shift - 1))) >> shift;
    if (v > lim) begin
      v = lim;
    end
    return v;
  endfunction

endpackage

// ----- hdl/mss_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface mss_in_if import mss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [AMP_W-1:0]   amplitude;
  logic [PHASE_W-1:0] phase_step;
  logic [PHASE_W-1:0] phase_start;

  modport source(output valid, op, amplitude, phase_step, phase_start, input ready);
  modport sink(input valid, op, amplitude, phase_step, phase_start, output ready);
endinterface

interface mss_out_if import mss_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       accepted;
  logic                       last;
  logic [COUNT_W-1:0]         harmonic_count;

  modport source(output valid, sample, accepted, last, harmonic_count, input ready);
  modport sink(input valid, sample, accepted, last, harmonic_count, output ready);
endinterface

interface mss_cfg_if import mss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/mss_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_ctrl
// Sequencer: decodes the op of an accepted item, steps the datapath through
// the harmonic visits of a tick, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mss_ctrl import mss_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] op,
  output logic            in_ready,
  output mss_cmd_t        cmd,
  input  mss_stat_t       stat
);

  state_t state, state_next;
  logic   is_tick, is_tick_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      is_tick <= 1'b0;
    end else begin
      state   <= state_next;
      is_tick <= is_tick_next;
    end
  end

  always_comb begin
    state_next   = state;
    is_tick_next = is_tick;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start    = 1'b1;
          is_tick_next = 1'b0;
          state_next   = ST_EMIT;
          case (op_t'(op))
            OP_ADD:   cmd.add = 1'b1;
            OP_CLEAR: cmd.clear = 1'b1;
            OP_TICK: begin
              cmd.tick_begin = 1'b1;
              is_tick_next   = 1'b1;
              state_next     = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (stat.visit_more) begin
          cmd.visit = 1'b1;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_tick = is_tick;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/mss_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_dpath
// Harmonic store, shared sine lookup / multiply / accumulate pipeline,
// record index, configuration registers and output register.
// ----------------------------------------------------------------------------
module mss_dpath import mss_pkg::*; #(
  parameter int MAX_HARMONICS   = MAX_HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int AMPLITUDE_BITS  = AMPLITUDE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mss_cmd_t                    cmd,
  output mss_stat_t                   stat,
  // item payload
  input  logic signed [AMP_W-1:0]     amplitude,
  input  logic [PHASE_W-1:0]          phase_step,
  input  logic [PHASE_W-1:0]          phase_start,
  // register writes
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  // result
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [SAMPLE_W-1:0]  out_sample,
  output logic                        out_accepted,
  output logic                        out_last,
  output logic [COUNT_W-1:0]          out_count
);

  localparam int QB      = SINE_TABLE_BITS - 2;
  localparam int QLEN    = 1 << QB;
  localparam int ROM_AW  = QB + 1;
  localparam int SINE_W  = AMPLITUDE_BITS;
  localparam int FRAC    = AMPLITUDE_BITS - 1;
  localparam int CNT_W   = $clog2(MAX_HARMONICS + 1);
  localparam int IDX_W   = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int PROD_W  = AMP_W + SINE_W;
  localparam int ACC_W   = PROD_W + CNT_W;
  localparam int RND_W   = ACC_W - FRAC;
  localparam int SUM_W   = (RND_W + 1 > SAMPLE_W + 1) ? RND_W + 1 : SAMPLE_W + 1;

  localparam logic [CNT_W-1:0]        CNT_FULL = CNT_W'(MAX_HARMONICS);
  localparam logic [ACC_W-1:0]        HALF_LSB = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'(SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO   = SUM_W'(SAMPLE_MIN);

  // ---------------- configuration ----------------
  logic signed [DC_W-1:0] dc_offset;
  logic [RLEN_W-1:0]      record_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_offset     <= '0;
      record_length <= RLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DC_OFFSET:     dc_offset <= cfg_data[DC_W-1:0];
        REG_RECORD_LENGTH: record_length <= cfg_data[RLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- quarter-wave table ----------------
  logic [SINE_W-1:0] sine_rom [QLEN+1];

  for (genvar g = 0; g <= QLEN; g++) begin : g_rom
    localparam logic [SINE_W-1:0] ENTRY = SINE_W'(sine_entry(g, QB, FRAC));
    assign sine_rom[g] = ENTRY;
  end

  // ---------------- harmonic store ----------------
  logic signed [AMP_W-1:0] amp_mem   [MAX_HARMONICS];
  logic [PHASE_W-1:0]      step_mem  [MAX_HARMONICS];
  logic [PHASE_W-1:0]      phase_mem [MAX_HARMONICS];

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] visit_ctr;
  logic             add_ok;

  assign add_ok = (count < CNT_FULL) && (phase_step <= NYQUIST);

  // pipeline registers
  logic                    v1, v2, v3;
  logic [IDX_W-1:0]        i1;
  logic signed [AMP_W-1:0] p_amp, s_amp;
  logic [PHASE_W-1:0]      p_phase, p_step;
  logic signed [SINE_W-1:0] s_mag;
  logic                    s_neg;
  logic signed [SINE_W-1:0] sine_val;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // phase index of the visited harmonic
  logic [SINE_TABLE_BITS-1:0] tab_p;
  logic [1:0]                 quad;
  logic [ROM_AW-1:0]          off;
  logic [ROM_AW-1:0]          rom_addr;

  assign tab_p    = p_phase[PHASE_W-1 -: SINE_TABLE_BITS];
  assign quad     = tab_p[QB+1:QB];
  assign off      = {1'b0, tab_p[QB-1:0]};
  assign rom_addr = quad[0] ? (ROM_AW'(QLEN) - off) : off;
  assign sine_val = s_neg ? -s_mag : s_mag;

  // store writes: add at the fill position, else phase advance from the registered read
  always_ff @(posedge clk) begin
    if (cmd.add && add_ok) begin
      amp_mem[count[IDX_W-1:0]]   <= amplitude;
      step_mem[count[IDX_W-1:0]]  <= phase_step;
      phase_mem[count[IDX_W-1:0]] <= phase_start;
    end else if (v1) begin
      phase_mem[i1] <= p_phase + p_step;
    end
  end

  // registered store read
  always_ff @(posedge clk) begin
    p_amp   <= amp_mem[visit_ctr[IDX_W-1:0]];
    p_step  <= step_mem[visit_ctr[IDX_W-1:0]];
    p_phase <= phase_mem[visit_ctr[IDX_W-1:0]];
    i1      <= visit_ctr[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    s_mag <= sine_rom[rom_addr];
    s_neg <= quad[1];
    s_amp <= p_amp;
    prod  <= s_amp * sine_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.visit;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_begin) begin
      acc <= '0;
    end else if (v3) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      visit_ctr <= '0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.add && add_ok) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.tick_begin) begin
        visit_ctr <= '0;
      end else if (cmd.visit) begin
        visit_ctr <= visit_ctr + CNT_W'(1);
      end
    end
  end

  assign stat.visit_more = visit_ctr < count;
  assign stat.pipe_empty = !v1 && !v2 && !v3;
  assign stat.out_free   = !out_valid || out_ready;

  // ---------------- rounding and record index ----------------
  logic [ACC_W-1:0]        rnd_sum;
  logic signed [RND_W-1:0] rnd;
  logic [INDEX_W-1:0]      sample_index;
  logic [INDEX_W-1:0]      len_m1;
  logic [RLEN_W-1:0]       rl_m1;
  logic                    at_end;
  logic                    res_last;
  logic                    res_accepted;

  assign rnd_sum = acc + HALF_LSB;
  assign rl_m1   = record_length - RLEN_W'(1);

  always_comb begin
    if (record_length < RLEN_W'(2)) begin
      len_m1 = INDEX_W'(1);
    end else if (record_length > RLEN_MAX) begin
      len_m1 = '1;
    end else begin
      len_m1 = rl_m1[INDEX_W-1:0];
    end
  end

  assign at_end = sample_index >= len_m1;

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      rnd <= rnd_sum[ACC_W-1:FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      res_last     <= 1'b0;
      res_accepted <= 1'b0;
    end else begin
      if (cmd.start) begin
        res_last     <= 1'b0;
        res_accepted <= cmd.add && add_ok;
      end
      if (cmd.clear) begin
        sample_index <= '0;
      end else if (cmd.round) begin
        res_last     <= at_end;
        sample_index <= at_end ? '0 : sample_index + INDEX_W'(1);
      end
    end
  end

  // ---------------- output register ----------------
  logic signed [SUM_W-1:0]    full_sum;
  logic signed [SAMPLE_W-1:0] sat_sample;
  logic [CNT_W+COUNT_W-1:0]   count_ext;

  assign full_sum  = SUM_W'(rnd) + SUM_W'(dc_offset);
  assign count_ext = {{COUNT_W{1'b0}}, count};

  always_comb begin
    if (full_sum > SAT_HI) begin
      sat_sample = SAMPLE_W'(SAMPLE_MAX);
    end else if (full_sum < SAT_LO) begin
      sat_sample = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sat_sample = full_sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample   <= cmd.emit_tick ? sat_sample : '0;
      out_last     <= cmd.emit_tick && res_last;
      out_accepted <= res_accepted;
      out_count    <= count_ext[COUNT_W-1:0];
    end
  end

endmodule

// ----- hdl/multitone_sine_synthesizer_core.sv -----
`timescale 1ns / 1ps
// Flow: a tick item visits its stored harmonics one after another through one
// shared lookup/multiplier, drains the pipeline, rounds and loads the result;
// other items load their result directly. One item in work; the next is taken
// once the result is loaded.
// Reset (rst, synchronous): harmonic table empty, sample index 0,
// dc_offset 0, record_length 1024.
// ----------------------------------------------------------------------------
// multitone_sine_synthesizer_core
// Multi-tone DDS generator: controller plus lookup/multiply/accumulate datapath.
// ----------------------------------------------------------------------------
module multitone_sine_synthesizer_core import mss_pkg::*; #(
  parameter int MAX_HARMONICS   = MAX_HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int AMPLITUDE_BITS  = AMPLITUDE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mss_in_if.sink     req,
  mss_out_if.source  rsp,
  mss_cfg_if.sink    cfg
);

  mss_cmd_t  cmd;
  mss_stat_t stat;

  assign cfg.ready = 1'b1;

  mss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .op       (req.op),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  mss_dpath #(
    .MAX_HARMONICS   (MAX_HARMONICS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .AMPLITUDE_BITS  (AMPLITUDE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .amplitude    (req.amplitude),
    .phase_step   (req.phase_step),
    .phase_start  (req.phase_start),
    .cfg_we       (cfg.valid && cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .out_sample   (rsp.sample),
    .out_accepted (rsp.accepted),
    .out_last     (rsp.last),
    .out_count    (rsp.harmonic_count)
  );

`ifndef SYNTH
  // one item in flight: no second accept right after the first
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("item accepted while previous item still in work");

  a_visit_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.visit |-> stat.visit_more)
    else $error("harmonic visit beyond stored count");

  a_tick_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_begin |-> stat.pipe_empty)
    else $error("tick started with pipeline not drained");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over an untaken result");
`endif

endmodule

// ----- dv/tb_multitone_sine_synthesizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multitone_sine_synthesizer_core
// Drives add, clear, tick and no-op items into the synthesiser core. A short
// table of directed items runs first, then random traffic in phases, each
// phase with a different dc_offset and record_length. A bit-accurate DDS
// model in the bench predicts each result not fixed by the directed table, and
// each result is checked field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_multitone_sine_synthesizer_core import mss_pkg::*; ();

  localparam int HARMONICS       = MAX_HARMONICS_DEF;
  localparam int QUARTER_LEN     = 256;
  localparam int DIRECTED_ROWS   = 22;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       accepted;
    logic                       last;
    logic [COUNT_W-1:0]         count;
  } synth_out_t;

  // typed = 1: the want fields are the expected result, else the model decides
  typedef struct packed {
    op_t                        op;
    logic [AMP_W-1:0]           amp;
    logic [PHASE_W-1:0]         step;
    logic [PHASE_W-1:0]         start;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] want_sample;
    logic                       want_acc;
    logic                       want_last;
    logic [COUNT_W-1:0]         want_count;
  } stim_row_t;

  logic clk;
  logic rst;
  bit   calm;
  int   mismatches;
  int   quiet_cycles;

  mss_in_if  req_ch ();
  mss_out_if rsp_ch ();
  mss_cfg_if cfg_ch ();

  multitone_sine_synthesizer_core uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // DDS state mirrored in the bench
  int                       qwave [QUARTER_LEN+1];
  logic signed [AMP_W-1:0]  tone_amp   [HARMONICS];
  logic [PHASE_W-1:0]       tone_step  [HARMONICS];
  logic [PHASE_W-1:0]       tone_phase [HARMONICS];
  int unsigned              tone_count;
  int unsigned              sample_idx;
  logic signed [DC_W-1:0]   dc_reg;
  logic [RLEN_W-1:0]        rlen_reg;

  synth_out_t dds_pending [$];

  stim_row_t directed [DIRECTED_ROWS] = '{
    // empty table straight after reset: sample is the zero offset
    '{OP_TICK,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 20'sd0, 1'b0, 1'b0, 4'd0},
    '{OP_NOP,   16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 20'sd0, 1'b0, 1'b0, 4'd0},
    // step of exactly half a cycle still passes, one LSB more does not
    '{OP_ADD,   16'h7FFF, 32'h8000_0000, 32'h0000_0000, 1'b1, 20'sd0, 1'b1, 1'b0, 4'd1},
    '{OP_ADD,   16'h8000, 32'h8000_0001, 32'h0000_0000, 1'b1, 20'sd0, 1'b0, 1'b0, 4'd1},
    '{OP_ADD,   16'h8000, 32'h0000_0000, 32'h4000_0000, 1'b1, 20'sd0, 1'b1, 1'b0, 4'd2},
    '{OP_TICK,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 20'sd0, 1'b0, 1'b0, 4'd0},
    '{OP_TICK,  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 20'sd0, 1'b0, 1'b0, 4'd0},
    '{OP_TICK,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 20'sd0, 1'b0, 1'b0, 4'd0},
    '{OP_ADD,   16'h7FFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 20'sd0, 1'b0, 1'b0, 4'd2},
    '{OP_ADD,   16'h0001, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 20'sd0, 1'b1, 1'b0, 4'd3},
    '{OP_ADD,   16'hFFFF, 32'h1234_5678, 32'hC000_0000, 1'b1, 20'sd0, 1'b1, 1'b0, 4'd4},
    '{OP_ADD,   16'h4000, 32'h0400_0000, 32'h8000_0000, 1'b1, 20'sd0, 1'b1, 1'b0, 4'd5},
    '{OP_ADD,   16'hC000, 32'h7FFF_FFFF, 32'h3FFF_FFFF, 1'b1, 20'sd0, 1'b1, 1'b0, 4'd6},
    '{OP_ADD,   16'h7FFF, 32'h0010_0000, 32'h4000_0000, 1'b1, 20'sd0, 1'b1, 1'b0, 4'd7},
    '{OP_ADD,   16'h7FFF, 32'h0000_0000, 32'h4000_0000, 1'b1, 20'sd0, 1'b1, 1'b0, 4'd8},
    // table full
    '{OP_ADD,   16'h1234, 32'h0000_0010, 32'h0000_0000, 1'b1, 20'sd0, 1'b0, 1'b0, 4'd8},
    '{OP_TICK,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 20'sd0, 1'b0, 1'b0, 4'd0},
    '{OP_TICK,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 20'sd0, 1'b0, 1'b0, 4'd0},
    '{OP_TICK,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 20'sd0, 1'b0, 1'b0, 4'd0},
    '{OP_NOP,   16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 20'sd0, 1'b0, 1'b0, 4'd8},
    '{OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 20'sd0, 1'b0, 1'b0, 4'd0},
    '{OP_TICK,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 20'sd0, 1'b0, 1'b0, 4'd0}
  };

  // quarter-wave entry: Q30 Taylor series, rounded half up to Q15, saturated
  function automatic int quarter_sine_entry(int unsigned i);
    longint unsigned x;
    longint unsigned term;
    longint unsigned s;
    longint unsigned v;
    x    = (64'(i) * HALF_PI_Q30 + 64'd128) / 64'd256;
    term = x;
    s    = x;
    for (int unsigned k = 1; k <= 9; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        s = s - term;
      end else begin
        s = s + term;
      end
    end
    v = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  function automatic longint tone_sine(logic [PHASE_W-1:0] phase);
    logic [9:0] p;
    longint     v;
    p = phase[31:22];
    v = p[8] ? longint'(qwave[QUARTER_LEN - int'(p[7:0])]) : longint'(qwave[p[7:0]]);
    return p[9] ? -v : v;
  endfunction

  function automatic synth_out_t dds_step(op_t op, logic [AMP_W-1:0] amp,
                                          logic [PHASE_W-1:0] step,
                                          logic [PHASE_W-1:0] start);
    synth_out_t  r;
    longint      acc;
    longint      total;
    int unsigned len;
    r = '0;
    case (op)
      OP_ADD: begin
        if (tone_count < HARMONICS && step <= NYQUIST) begin
          tone_amp[tone_count]   = amp;
          tone_step[tone_count]  = step;
          tone_phase[tone_count] = start;
          tone_count++;
          r.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        tone_count = 0;
        sample_idx = 0;
      end
      OP_TICK: begin
        acc = 0;
        len = rlen_reg;
        if (len < 2) len = 2;
        if (len > RLEN_MAX) len = RLEN_MAX;
        for (int unsigned i = 0; i < tone_count; i++) begin
          acc += longint'(tone_amp[i]) * tone_sine(tone_phase[i]);
          tone_phase[i] = tone_phase[i] + tone_step[i];
        end
        // floor of (acc + half) / 2^15 rounds half toward +inf
        total = ((acc + 64'sd16384) >>> 15) + longint'(dc_reg);
        if (total > SAMPLE_MAX) total = SAMPLE_MAX;
        if (total < SAMPLE_MIN) total = SAMPLE_MIN;
        r.sample = total[SAMPLE_W-1:0];
        if (sample_idx >= len - 1) begin
          r.last     = 1'b1;
          sample_idx = 0;
        end else begin
          sample_idx++;
        end
      end
      default: ;
    endcase
    r.count = tone_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void dds_write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DC_OFFSET:     dc_reg   = data[DC_W-1:0];
      REG_RECORD_LENGTH: rlen_reg = data[RLEN_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    mismatches++;
    $display("%0t ns  %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // drives one item, waits for it to be taken, returns the predicted result
  task automatic put_item(op_t op, logic [AMP_W-1:0] amp, logic [PHASE_W-1:0] step,
                          logic [PHASE_W-1:0] start, output synth_out_t res);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 14) gap++;
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.amplitude   <= amp;
    req_ch.phase_step  <= step;
    req_ch.phase_start <= start;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    res = dds_step(op, amp, step, start);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (dds_pending.size() != 0);
  endtask

  task automatic write_regs(logic [CFG_DATA_W-1:0] dc_data, logic [CFG_DATA_W-1:0] rl_data);
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
    for (int n = 0; n < 2; n++) begin
      idx  = (n == 0) ? REG_DC_OFFSET : REG_RECORD_LENGTH;
      data = (n == 0) ? dc_data : rl_data;
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= data;
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      dds_write_reg(idx, data);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = ~clk;
  end

  // result side: random back-pressure and checking
  always @(posedge clk) begin : rsp_check
    synth_out_t want;
    rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (dds_pending.size() == 0) begin
        report_mismatch("result item with nothing outstanding", 0, rsp_ch.sample);
      end else begin
        want = dds_pending.pop_front();
        if (rsp_ch.sample !== want.sample)
          report_mismatch("sample", want.sample, rsp_ch.sample);
        if (rsp_ch.accepted !== want.accepted)
          report_mismatch("accepted", want.accepted, rsp_ch.accepted);
        if (rsp_ch.last !== want.last)
          report_mismatch("last", want.last, rsp_ch.last);
        if (rsp_ch.harmonic_count !== want.count)
          report_mismatch("harmonic_count", want.count, rsp_ch.harmonic_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_multitone_sine_synthesizer_core NOT OK");
      $finish;
    end
  end

  initial begin
    synth_out_t            res;
    op_t                   op;
    logic [AMP_W-1:0]      amp;
    logic [PHASE_W-1:0]    step;
    logic [PHASE_W-1:0]    start;
    logic [CFG_DATA_W-1:0] dc_data;
    logic [CFG_DATA_W-1:0] rl_data;
    int                    sel;

    rst                = 1'b1;
    calm               = 1'b0;
    mismatches         = 0;
    quiet_cycles       = 0;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_NOP;
    req_ch.amplitude   = '0;
    req_ch.phase_step  = '0;
    req_ch.phase_start = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_DC_OFFSET;
    cfg_ch.data        = '0;

    for (int i = 0; i <= QUARTER_LEN; i++) qwave[i] = quarter_sine_entry(i);
    for (int i = 0; i < HARMONICS; i++) begin
      tone_amp[i]   = '0;
      tone_step[i]  = '0;
      tone_phase[i] = '0;
    end
    tone_count = 0;
    sample_idx = 0;
    dc_reg     = '0;
    rlen_reg   = RLEN_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      put_item(directed[i].op, directed[i].amp, directed[i].step, directed[i].start, res);
      if (directed[i].typed) begin
        res.sample   = directed[i].want_sample;
        res.accepted = directed[i].want_acc;
        res.last     = directed[i].want_last;
        res.count    = directed[i].want_count;
      end
      dds_pending = {dds_pending, res};
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      calm    = 1'b0;
      dc_data = CFG_DATA_W'($urandom);
      case (ph)
        0: begin
          dc_data = 21'h00_8000;
          rl_data = 21'd2;
        end
        1: begin
          dc_data = 21'h1F_7FFF;
          rl_data = 21'd1048576;
        end
        2: begin
          dc_data = 21'd0;
          rl_data = 21'd0;
        end
        3: rl_data = 21'h1F_FFFF;
        4: rl_data = 21'd1;
        5: begin
          rl_data = 21'd1024;
          calm    = 1'b1;
        end
        default: rl_data = CFG_DATA_W'($urandom_range(3, 40));
      endcase
      write_regs(dc_data, rl_data);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel   = $urandom_range(99);
        amp   = AMP_W'($urandom);
        start = $urandom;
        if (sel < 55) op = OP_TICK;
        else if (sel < 88) op = OP_ADD;
        else if (sel < 92) op = OP_CLEAR;
        else op = OP_NOP;
        sel = $urandom_range(99);
        if (sel < 50) step = $urandom_range(0, 32'h8000_0000);
        else if (sel < 70) step = $urandom_range(0, 32'h00FF_FFFF);
        else if (sel < 90) step = $urandom;
        else if (sel < 95) step = NYQUIST;
        else step = NYQUIST + 32'd1;
        if ($urandom_range(149) == 0) drain_results();
        put_item(op, amp, step, start, res);
        dds_pending = {dds_pending, res};
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_multitone_sine_synthesizer_core OK");
    end else begin
      $display("tb_multitone_sine_synthesizer_core NOT OK");
    end
    $finish;
  end

endmodule
